// ===== src/cfr_pkg.sv =====
package cfr_pkg;

    // table geometry
    localparam int FRAMES     = 64;
    localparam int PAGE_BITS  = 20;
    localparam int IDX_W      = $clog2(FRAMES);
    localparam int SCAN_LIMIT = 2 * FRAMES + 1;
    localparam int STEP_W     = $clog2(SCAN_LIMIT);

    // port field widths
    localparam int OP_W     = 3;
    localparam int FRAME_W  = 6;
    localparam int PAGE_W   = 20;
    localparam int STATUS_W = 2;

    // opcodes
    localparam logic [OP_W-1:0] OP_ALLOC = 3'd0;
    localparam logic [OP_W-1:0] OP_FREE  = 3'd1;
    localparam logic [OP_W-1:0] OP_PIN   = 3'd2;
    localparam logic [OP_W-1:0] OP_UNPIN = 3'd3;
    localparam logic [OP_W-1:0] OP_TOUCH = 3'd4;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOFRAME = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNUSED  = 2'd2;

    // one slot as held in the slot ram
    typedef struct packed {
        logic                 pinned;
        logic                 accessed;
        logic [PAGE_BITS-1:0] page;
    } slot_word_t;

    localparam int SLOT_W = $bits(slot_word_t);

    typedef enum logic [3:0] {
        FSM_IDLE = 4'b0001,
        FSM_EXEC = 4'b0010,
        FSM_RMW  = 4'b0100,
        FSM_SCAN = 4'b1000
    } fsm_t;

    // clock hand advance, wrapping over slot order
    function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] s);
        logic [IDX_W-1:0] r;
        r = (s == IDX_W'(FRAMES - 1)) ? '0 : s + 1'b1;
        return r;
    endfunction

endpackage

// ===== src/cfr_ram.sv =====
module cfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/clock_frame_replacer_unit.sv =====
// result path: free, unused opcodes, errors and allocate into a free slot give their result
//   from the execute state; pin, unpin and mark accessed read the slot, then write it back
// eviction: the clock hand examines one slot per cycle (1 to 2*FRAMES+1 slots, via the
//   one-read-per-cycle slot ram)
// flow: one word in flight; the next is taken the cycle after a result is loaded,
//   and execution waits while an earlier result is still held
// reset: valid bits cleared, clock hand on the last slot; slot ram is not cleared
module clock_frame_replacer_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [cfr_pkg::OP_W-1:0]     opcode,
    input  logic [cfr_pkg::PAGE_W-1:0]   page_number,
    input  logic [cfr_pkg::FRAME_W-1:0]  frame_index,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [cfr_pkg::FRAME_W-1:0]  result_frame,
    output logic                         evicted,
    output logic [cfr_pkg::PAGE_W-1:0]   evicted_page,
    output logic [cfr_pkg::STATUS_W-1:0] status
);

    import cfr_pkg::*;

    // control state
    fsm_t              state_reg, state_next;
    logic [FRAMES-1:0] valid_reg, valid_next;
    logic [IDX_W-1:0]  hand_reg, hand_next;
    logic [IDX_W-1:0]  scan_addr_reg, scan_addr_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              out_valid_reg, out_valid_next;

    // captured input word
    logic [OP_W-1:0]    op_reg;
    logic [PAGE_W-1:0]  page_reg;
    logic [FRAME_W-1:0] fi_reg;

    // output register
    logic [FRAME_W-1:0]  res_frame_reg, res_frame_next;
    logic                ev_reg, ev_next;
    logic [PAGE_W-1:0]   ev_page_reg, ev_page_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic                load_out;

    // slot ram port
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [IDX_W-1:0] ram_raddr;
    slot_word_t       ram_wdata;
    slot_word_t       ram_rdata;

    // decode helpers
    logic              in_accept;
    logic              out_free;
    logic              all_valid;
    logic [IDX_W-1:0]  free_idx;
    logic [IDX_W-1:0]  fi_idx;
    logic              slot_ok;
    logic [IDX_W-1:0]  scan_adv;
    logic [IDX_W-1:0]  hand_adv;
    slot_word_t        new_word;

    cfr_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (FRAMES)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_stall  = (state_reg != FSM_IDLE);
    assign in_accept = in_valid && !in_stall;
    // result slot is usable when empty or being drained this cycle
    assign out_free  = !out_valid_reg || !out_stall;

    assign all_valid = &valid_reg;
    assign fi_idx    = IDX_W'(fi_reg);
    assign slot_ok   = (int'(fi_reg) < FRAMES) && valid_reg[fi_idx];
    assign scan_adv  = next_slot(scan_addr_reg);
    assign hand_adv  = next_slot(hand_reg);

    // a newly installed page is pinned with its accessed bit clear
    assign new_word.pinned   = 1'b1;
    assign new_word.accessed = 1'b0;
    assign new_word.page     = PAGE_BITS'(page_reg);

    // lowest free slot
    always_comb
    begin
        free_idx = '0;
        for (int i = FRAMES - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_idx = IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        valid_next     = valid_reg;
        hand_next      = hand_reg;
        scan_addr_next = scan_addr_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;

        load_out       = 1'b0;
        res_frame_next = fi_reg;
        ev_next        = 1'b0;
        ev_page_next   = '0;
        status_next    = ST_OK;

        ram_we    = 1'b0;
        ram_waddr = scan_addr_reg;
        ram_wdata = ram_rdata;
        ram_raddr = scan_addr_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            FSM_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = FSM_EXEC;
                end
            end

            FSM_EXEC:
            begin
                if (out_free)
                begin
                    case (op_reg) inside
                        OP_ALLOC:
                        begin
                            if (!all_valid)
                            begin
                                // free slot: install directly
                                ram_we               = 1'b1;
                                ram_waddr            = free_idx;
                                ram_wdata            = new_word;
                                valid_next[free_idx] = 1'b1;
                                res_frame_next       = FRAME_W'(free_idx);
                                load_out             = 1'b1;
                                state_next           = FSM_IDLE;
                            end
                            else
                            begin
                                // table full: start the clock hand sweep
                                ram_raddr      = hand_adv;
                                scan_addr_next = hand_adv;
                                step_next      = '0;
                                state_next     = FSM_SCAN;
                            end
                        end

                        OP_FREE, OP_PIN, OP_UNPIN, OP_TOUCH:
                        begin
                            if (!slot_ok)
                            begin
                                status_next = ST_UNUSED;
                                load_out    = 1'b1;
                                state_next  = FSM_IDLE;
                            end
                            else if (op_reg == OP_FREE)
                            begin
                                // flags of an invalid slot are never looked at
                                valid_next[fi_idx] = 1'b0;
                                load_out           = 1'b1;
                                state_next         = FSM_IDLE;
                            end
                            else
                            begin
                                ram_raddr      = fi_idx;
                                scan_addr_next = fi_idx;
                                state_next     = FSM_RMW;
                            end
                        end

                        default:
                        begin
                            load_out   = 1'b1;
                            state_next = FSM_IDLE;
                        end
                    endcase
                end
            end

            FSM_RMW:
            begin
                // flag update on the word read last cycle
                ram_we    = 1'b1;
                ram_waddr = scan_addr_reg;
                ram_wdata = ram_rdata;
                case (op_reg)
                    OP_PIN:   ram_wdata.pinned   = 1'b1;
                    OP_UNPIN: ram_wdata.pinned   = 1'b0;
                    default:  ram_wdata.accessed = 1'b1;
                endcase
                load_out   = 1'b1;
                state_next = FSM_IDLE;
            end

            FSM_SCAN:
            begin
                // ram_rdata holds the slot under the hand; next read issued in parallel
                hand_next = scan_addr_reg;
                if (!ram_rdata.pinned && !ram_rdata.accessed)
                begin
                    ram_we         = 1'b1;
                    ram_waddr      = scan_addr_reg;
                    ram_wdata      = new_word;
                    res_frame_next = FRAME_W'(scan_addr_reg);
                    ev_next        = 1'b1;
                    ev_page_next   = PAGE_W'(ram_rdata.page);
                    load_out       = 1'b1;
                    state_next     = FSM_IDLE;
                end
                else
                begin
                    if (!ram_rdata.pinned)
                    begin
                        // second chance: clear the accessed bit
                        ram_we             = 1'b1;
                        ram_waddr          = scan_addr_reg;
                        ram_wdata          = ram_rdata;
                        ram_wdata.accessed = 1'b0;
                    end
                    if (step_reg == STEP_W'(SCAN_LIMIT - 1))
                    begin
                        res_frame_next = '0;
                        status_next    = ST_NOFRAME;
                        load_out       = 1'b1;
                        state_next     = FSM_IDLE;
                    end
                    else
                    begin
                        step_next      = step_reg + 1'b1;
                        scan_addr_next = scan_adv;
                        ram_raddr      = scan_adv;
                    end
                end
            end

            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase

        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= FSM_IDLE;
            valid_reg     <= '0;
            hand_reg      <= IDX_W'(FRAMES - 1);
            scan_addr_reg <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            hand_reg      <= hand_next;
            scan_addr_reg <= scan_addr_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            op_reg   <= opcode;
            page_reg <= page_number;
            fi_reg   <= frame_index;
        end
        if (load_out)
        begin
            res_frame_reg <= res_frame_next;
            ev_reg        <= ev_next;
            ev_page_reg   <= ev_page_next;
            status_reg    <= status_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_frame = res_frame_reg;
    assign evicted      = ev_reg;
    assign evicted_page = ev_page_reg;
    assign status       = status_reg;

    // sweep only runs over a full table
    a_scan_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == FSM_SCAN) |-> all_valid)
        else $error("clock sweep with a free slot present");

    // sweep step count stays under the limit
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == FSM_SCAN) |-> (int'(step_reg) < SCAN_LIMIT))
        else $error("clock sweep ran past its limit");

    // sweep writeback never collides with the look-ahead read
    a_scan_rw: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == FSM_SCAN) && ram_we && !load_out) |-> (ram_waddr != ram_raddr))
        else $error("sweep write and read hit the same slot");

    // an eviction always reports ok
    a_evict_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (load_out && ev_next) |-> (status_next == ST_OK))
        else $error("eviction with error status");

    // an accepted word starts execution next cycle
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg == FSM_EXEC))
        else $error("accepted word not executed");

endmodule

// ===== dv/clock_frame_replacer_unit_test.sv =====
`timescale 1ns / 1ps

module clock_frame_replacer_unit_test;

    import cfr_pkg::*;

    // opcodes the block ignores, echoing frame_index with an ok status
    localparam logic [OP_W-1:0] OP_SPARE_LO  = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_MID = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_HI  = 3'd7;

    localparam int RANDOM_WORDS   = 700;
    localparam int HOLD_AT        = 150;   // random word after which the sink holds off
    localparam int HOLD_CYCLES    = 220;
    localparam int DRAIN_AT       = 400;   // random word after which the source drains
    localparam int BURST_FIRST    = 500;   // no idling on either side in this window
    localparam int BURST_LAST     = 600;
    localparam int SETTLE_CYCLES  = SCAN_LIMIT + 8;
    // worst quiet stretch: sink hold-off, then a full sweep, a stall and a gap
    localparam int WATCHDOG_LIMIT = 4 * (HOLD_CYCLES + SCAN_LIMIT + 2 + 19 + 19);

    typedef struct packed {
        logic [FRAME_W-1:0]  slot;
        logic                evicted;
        logic [PAGE_W-1:0]   evicted_page;
        logic [STATUS_W-1:0] status;
    } frame_result_t;

    // one row of the directed table; reps > 1 steps page and slot by one per word
    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [PAGE_W-1:0]  page;
        logic [FRAME_W-1:0] slot;
        logic [7:0]         reps;
        logic               hand_checked;
        frame_result_t      want;
    } stim_row_t;

    localparam frame_result_t NO_RESULT     = '0;
    localparam int            DIRECTED_ROWS = 25;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid;
    logic                in_stall;
    logic [OP_W-1:0]     opcode;
    logic [PAGE_W-1:0]   page_number;
    logic [FRAME_W-1:0]  frame_index;
    logic                out_valid;
    logic                out_stall;
    logic [FRAME_W-1:0]  result_frame;
    logic                evicted;
    logic [PAGE_W-1:0]   evicted_page;
    logic [STATUS_W-1:0] status;

    clock_frame_replacer_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .page_number  (page_number),
        .frame_index  (frame_index),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_frame (result_frame),
        .evicted      (evicted),
        .evicted_page (evicted_page),
        .status       (status)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // directed walk: empty-table errors, ignored opcodes, lowest-free-slot
    // placement, a fill to a full table, eviction, a fully pinned table, a
    // second-chance pass over an accessed slot, and free-then-allocate at the top slot
    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        '{OP_FREE,      20'h00000, 6'd0,  8'd1,  1'b1, '{6'd0,  1'b0, 20'h0, ST_UNUSED}},
        '{OP_PIN,       20'h00000, 6'd63, 8'd1,  1'b1, '{6'd63, 1'b0, 20'h0, ST_UNUSED}},
        '{OP_UNPIN,     20'h00000, 6'd5,  8'd1,  1'b1, '{6'd5,  1'b0, 20'h0, ST_UNUSED}},
        '{OP_TOUCH,     20'hFFFFF, 6'd42, 8'd1,  1'b1, '{6'd42, 1'b0, 20'h0, ST_UNUSED}},
        '{OP_SPARE_LO,  20'h00000, 6'd21, 8'd1,  1'b1, '{6'd21, 1'b0, 20'h0, ST_OK}},
        '{OP_SPARE_MID, 20'hFFFFF, 6'd63, 8'd1,  1'b1, '{6'd63, 1'b0, 20'h0, ST_OK}},
        '{OP_SPARE_HI,  20'h00000, 6'd0,  8'd1,  1'b1, '{6'd0,  1'b0, 20'h0, ST_OK}},
        '{OP_ALLOC,     20'hFFFFF, 6'd63, 8'd1,  1'b1, '{6'd0,  1'b0, 20'h0, ST_OK}},
        '{OP_ALLOC,     20'h00000, 6'd0,  8'd1,  1'b1, '{6'd1,  1'b0, 20'h0, ST_OK}},
        '{OP_ALLOC,     20'hA5A5A, 6'd17, 8'd1,  1'b1, '{6'd2,  1'b0, 20'h0, ST_OK}},
        '{OP_FREE,      20'h00000, 6'd1,  8'd1,  1'b1, '{6'd1,  1'b0, 20'h0, ST_OK}},
        '{OP_ALLOC,     20'h5A5A5, 6'd0,  8'd1,  1'b1, '{6'd1,  1'b0, 20'h0, ST_OK}},
        '{OP_TOUCH,     20'h00000, 6'd0,  8'd1,  1'b1, '{6'd0,  1'b0, 20'h0, ST_OK}},
        '{OP_UNPIN,     20'h00000, 6'd2,  8'd1,  1'b1, '{6'd2,  1'b0, 20'h0, ST_OK}},
        '{OP_ALLOC,     20'h10000, 6'd0,  8'd61, 1'b0, NO_RESULT},
        '{OP_ALLOC,     20'h12345, 6'd0,  8'd1,  1'b0, NO_RESULT},
        '{OP_ALLOC,     20'h54321, 6'd0,  8'd1,  1'b1, '{6'd0,  1'b0, 20'h0, ST_NOFRAME}},
        '{OP_UNPIN,     20'h00000, 6'd0,  8'd1,  1'b1, '{6'd0,  1'b0, 20'h0, ST_OK}},
        '{OP_ALLOC,     20'hABCDE, 6'd0,  8'd1,  1'b0, NO_RESULT},
        '{OP_UNPIN,     20'h00000, 6'd63, 8'd1,  1'b0, NO_RESULT},
        '{OP_TOUCH,     20'h00000, 6'd63, 8'd1,  1'b0, NO_RESULT},
        '{OP_UNPIN,     20'h00000, 6'd62, 8'd1,  1'b0, NO_RESULT},
        '{OP_ALLOC,     20'h00001, 6'd0,  8'd1,  1'b0, NO_RESULT},
        '{OP_FREE,      20'h00000, 6'd63, 8'd1,  1'b1, '{6'd63, 1'b0, 20'h0, ST_OK}},
        '{OP_ALLOC,     20'hFFFFF, 6'd0,  8'd1,  1'b1, '{6'd63, 1'b0, 20'h0, ST_OK}}
    };

    // shadow of the frame table, advanced once per accepted word
    logic               slot_used    [FRAMES];
    logic               slot_locked  [FRAMES];
    logic               slot_touched [FRAMES];
    logic [PAGE_W-1:0]  slot_owner   [FRAMES];
    logic [IDX_W-1:0]   sweep_pos;

    frame_result_t pending_results [$];

    int unsigned fail_count   = 0;
    int unsigned n_words      = 0;
    int unsigned n_directed   = 0;
    int unsigned n_checked    = 0;
    int unsigned n_evictions  = 0;
    int unsigned n_refusals   = 0;
    int unsigned n_unused     = 0;
    int unsigned quiet_cycles = 0;
    logic        rx_hold_req  = 1'b0;
    logic        no_idle      = 1'b0;

    function automatic void seat_page(input int s, input logic [PAGE_W-1:0] pg);
        slot_used[s]    = 1'b1;
        slot_locked[s]  = 1'b1;
        slot_touched[s] = 1'b0;
        slot_owner[s]   = pg;
    endfunction

    // what the block must answer for one word, updating the shadow table
    function automatic frame_result_t apply_frame_op(input logic [OP_W-1:0] op,
                                                     input logic [PAGE_W-1:0] pg,
                                                     input logic [FRAME_W-1:0] fi);
        frame_result_t r;
        logic          placed;
        r      = '{slot: fi, evicted: 1'b0, evicted_page: '0, status: ST_OK};
        placed = 1'b0;
        if (op == OP_ALLOC)
        begin
            r.slot = '0;
            // lowest free slot first
            for (int s = 0; s < FRAMES && !placed; s++)
            begin
                if (!slot_used[s])
                begin
                    seat_page(s, pg);
                    r.slot = FRAME_W'(s);
                    placed = 1'b1;
                end
            end
            // table full: second-chance sweep, pinned slots skipped
            for (int n = 0; n < SCAN_LIMIT && !placed; n++)
            begin
                sweep_pos = (sweep_pos == IDX_W'(FRAMES - 1)) ? '0 : sweep_pos + 1'b1;
                if (!slot_locked[sweep_pos])
                begin
                    if (slot_touched[sweep_pos])
                        slot_touched[sweep_pos] = 1'b0;
                    else
                    begin
                        r.evicted      = 1'b1;
                        r.evicted_page = slot_owner[sweep_pos];
                        seat_page(int'(sweep_pos), pg);
                        r.slot = FRAME_W'(sweep_pos);
                        placed = 1'b1;
                    end
                end
            end
            if (!placed)
                r.status = ST_NOFRAME;
        end
        else if (op <= OP_TOUCH)
        begin
            if (!slot_used[fi])
                r.status = ST_UNUSED;
            else if (op == OP_FREE)
            begin
                slot_used[fi]    = 1'b0;
                slot_locked[fi]  = 1'b0;
                slot_touched[fi] = 1'b0;
            end
            else if (op == OP_PIN)
                slot_locked[fi] = 1'b1;
            else if (op == OP_UNPIN)
                slot_locked[fi] = 1'b0;
            else
                slot_touched[fi] = 1'b1;
        end
        return r;
    endfunction

    function automatic logic [FRAME_W-1:0] pick_frame();
        int live [$];
        if ($urandom_range(0, 99) < 85)
        begin
            for (int s = 0; s < FRAMES; s++)
                if (slot_used[s])
                    live.push_back(s);
            if (live.size() != 0)
                return FRAME_W'(live[$urandom_range(0, live.size() - 1)]);
        end
        return FRAME_W'($urandom_range(0, FRAMES - 1));
    endfunction

    function automatic logic [PAGE_W-1:0] pick_page();
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
            return '1;
        if (roll == 1)
            return '0;
        return PAGE_W'($urandom);
    endfunction

    // offer one word after a random gap, hold it until taken, then log what it must produce
    task automatic send_word(input logic [OP_W-1:0] op, input logic [PAGE_W-1:0] pg,
                             input logic [FRAME_W-1:0] fi, input logic hand_checked,
                             input frame_result_t typed_want);
        int unsigned   gap;
        frame_result_t want;
        gap = no_idle ? 0 : $urandom_range(0, 19);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        opcode      <= op;
        page_number <= pg;
        frame_index <= fi;
        do @(posedge clk); while (in_stall);
        want = apply_frame_op(op, pg, fi);
        if (want.evicted)
            n_evictions++;
        if (want.status == ST_NOFRAME)
            n_refusals++;
        if (want.status == ST_UNUSED)
            n_unused++;
        pending_results.push_back(hand_checked ? typed_want : want);
        n_words++;
    endtask

    task automatic flag_mismatch(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        fail_count++;
        if (fail_count <= 10)
            $display("mismatch in result %0d, %s: expected 0x%0h, got 0x%0h",
                     n_checked, field, want, got);
    endtask

    task automatic check_result(input frame_result_t got);
        frame_result_t want;
        if (pending_results.size() == 0)
        begin
            fail_count++;
            if (fail_count <= 10)
                $display("result with no word pending: slot %0d status %0d",
                         got.slot, got.status);
            return;
        end
        want = pending_results.pop_front();
        if (got.slot !== want.slot)
            flag_mismatch("result_frame", 32'(want.slot), 32'(got.slot));
        if (got.evicted !== want.evicted)
            flag_mismatch("evicted", 32'(want.evicted), 32'(got.evicted));
        if (got.evicted_page !== want.evicted_page)
            flag_mismatch("evicted_page", 32'(want.evicted_page), 32'(got.evicted_page));
        if (got.status !== want.status)
            flag_mismatch("status", 32'(want.status), 32'(got.status));
        n_checked++;
    endtask

    // result sink: random stall before each word, one long hold-off on request
    initial
    begin : result_sink
        int unsigned   hold;
        frame_result_t got;
        out_stall <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (rx_hold_req)
            begin
                rx_hold_req = 1'b0;
                hold        = HOLD_CYCLES;
            end
            else if (no_idle)
                hold = 0;
            else
                hold = $urandom_range(0, 19);
            if (hold != 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
            got = '{slot: result_frame, evicted: evicted, evicted_page: evicted_page,
                    status: status};
            check_result(got);
        end
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("no word moved for %0d cycles, %0d results still pending",
                         quiet_cycles, pending_results.size());
                $display("[clock_frame_replacer_unit] ERROR");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int unsigned        counted;
        int unsigned        roll;
        int unsigned        live_count;
        logic [OP_W-1:0]    op;
        logic [PAGE_W-1:0]  pg;
        logic [FRAME_W-1:0] fi;

        in_valid    <= 1'b0;
        opcode      <= OP_ALLOC;
        page_number <= '0;
        frame_index <= '0;
        for (int s = 0; s < FRAMES; s++)
        begin
            slot_used[s]    = 1'b0;
            slot_locked[s]  = 1'b0;
            slot_touched[s] = 1'b0;
            slot_owner[s]   = '0;
        end
        sweep_pos = IDX_W'(FRAMES - 1);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed table
        for (int r = 0; r < DIRECTED_ROWS; r++)
            for (int k = 0; k < int'(directed_rows[r].reps); k++)
                send_word(directed_rows[r].op,
                          directed_rows[r].page + PAGE_W'(k),
                          directed_rows[r].slot + FRAME_W'(k),
                          directed_rows[r].hand_checked, directed_rows[r].want);
        n_directed = n_words;

        // random part: mostly words on live slots, weighted to keep the table
        // full and churning through unpin / touch / evict; the rest is noise
        counted = 0;
        while (counted < RANDOM_WORDS)
        begin
            live_count = 0;
            for (int s = 0; s < FRAMES; s++)
                if (slot_used[s])
                    live_count++;
            roll = $urandom_range(0, 99);
            if (roll < 3)
                op = OP_SPARE_LO + OP_W'($urandom_range(0, OP_SPARE_HI - OP_SPARE_LO));
            else if (roll < 30 || (live_count < FRAMES && roll < 45))
                op = OP_ALLOC;
            else if (roll < 55)
                op = OP_UNPIN;
            else if (roll < 70)
                op = OP_TOUCH;
            else if (roll < 82)
                op = OP_PIN;
            else
                op = OP_FREE;
            pg = pick_page();
            fi = pick_frame();
            send_word(op, pg, fi, 1'b0, NO_RESULT);

            // spare opcodes are ignored by the block and not counted
            if (op <= OP_TOUCH)
            begin
                counted++;
                if (counted == HOLD_AT)
                    rx_hold_req = 1'b1;   // sink stops, source keeps offering
                if (counted == DRAIN_AT)
                begin
                    in_valid <= 1'b0;
                    while (pending_results.size() != 0)
                        @(posedge clk);
                end
                no_idle = (counted >= BURST_FIRST && counted < BURST_LAST);
            end
        end
        in_valid <= 1'b0;
        no_idle = 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        // anything arriving now is an unexpected result
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("covered %0d words (%0d directed): %0d evictions, %0d fully pinned refusals, %0d on unused slots",
                 n_words, n_directed, n_evictions, n_refusals, n_unused);
        $display("checked %0d results, %0d failures", n_checked, fail_count);
        if (fail_count == 0 && pending_results.size() == 0)
            $display("[clock_frame_replacer_unit] OK");
        else
            $display("[clock_frame_replacer_unit] ERROR");
        $finish;
    end

endmodule
